// ----- rtl/core/frgt_pkg.sv -----
// ----------------------------------------------------------------------------
// frgt_pkg
// shared types and constants of the frame rms gain tracker
// ----------------------------------------------------------------------------
package frgt_pkg;

	localparam int MaxFrameSamples = 4096;
	localparam int CountW = $clog2(MaxFrameSamples + 1);
	localparam logic [31:0] GainOne = 32'h0001_0000;
	localparam int QueueDepth = 4;
	localparam int QueueAw = $clog2(QueueDepth);

	localparam logic [1:0] CfgEnable = 2'd0;
	localparam logic [1:0] CfgTarget = 2'd1;
	localparam logic [1:0] CfgFormat = 2'd2;

	localparam logic [1:0] FmtInt8 = 2'd0;
	localparam logic [1:0] FmtInt16 = 2'd1;
	localparam logic [1:0] FmtInt24 = 2'd2;
	localparam logic [1:0] FmtInt32 = 2'd3;

	// one finished frame handed from front to back
	typedef struct packed {
		logic [63:0] square_sum;
		logic [CountW-1:0] sample_count;
	} frame_t;

	typedef struct packed {
		logic [31:0] gain_fixed;
		logic [15:0] gain_whole;
		logic [31:0] frame_level;
	} result_t;

endpackage

// ----- rtl/core/frgt_if.sv -----
// ----------------------------------------------------------------------------
// frgt_sample_if / frgt_result_if
// valid/ready channels of the frame rms gain tracker
// ----------------------------------------------------------------------------
interface frgt_sample_if;
	logic valid;
	logic ready;
	logic [31:0] sample_word;
	logic frame_last;
	modport source (output valid, output sample_word, output frame_last, input ready);
	modport sink (input valid, input sample_word, input frame_last, output ready);
endinterface

interface frgt_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] gain_fixed;
	logic signed [15:0] gain_whole;
	logic [31:0] frame_level;
	modport source (output valid, output gain_fixed, output gain_whole, output frame_level,
		input ready);
	modport sink (input valid, input gain_fixed, input gain_whole, input frame_level,
		output ready);
endinterface

// ----- rtl/core/frame_rms_gain_tracker.sv -----
// ----------------------------------------------------------------------------
// frame_rms_gain_tracker
// rms level measurement with gain tracking per audio frame
// ----------------------------------------------------------------------------
// usage:
// samples enter on the sample channel, one item per sample, frame_last on the
// final sample of a frame. the front squares and accumulates at one item per
// cycle while no frame end waits on a full queue (two-stage pipeline). each
// frame end goes into a four-entry queue; the back pops it and runs a
// 64-step restoring divide by the sample count, a 32-step square root and a
// reciprocal multiply of four partial products for the divide by 625, one
// frame at a time; the result carries gain_fixed, gain_whole and frame_level.
// the result register holds while the receiver stalls; samples keep flowing
// until the queue is full and a frame end is pending.
// configuration is written through cfg_we/cfg_index/cfg_data while idle;
// writing enable=1 resets the gain to one and the stored error to zero.
// reset: enable 0, target 100, format int16, gain one, sums cleared.
// ----------------------------------------------------------------------------
module frame_rms_gain_tracker import frgt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [30:0] cfg_data,
	frgt_sample_if.sink samples,
	frgt_result_if.source results
);

	logic enable_q;
	logic [30:0] target_q;
	logic [1:0] format_q;
	logic gain_reset;
	logic push, full, nonempty, pop;
	frame_t push_data, head;
	result_t res;

	assign gain_reset = cfg_we && cfg_index == CfgEnable && cfg_data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			target_q <= 31'd100;
			format_q <= FmtInt16;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgEnable: enable_q <= cfg_data[0];
				CfgTarget: target_q <= cfg_data;
				CfgFormat: format_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	frgt_front u_front (
		.clk, .arst_n,
		.active(enable_q && target_q != '0),
		.sample_format(format_q),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.sample_word(samples.sample_word),
		.frame_last(samples.frame_last),
		.push, .push_data,
		.queue_full(full)
	);

	frgt_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full, .nonempty, .pop, .head
	);

	frgt_back u_back (
		.clk, .arst_n, .gain_reset,
		.target_level(target_q),
		.frame_valid(nonempty),
		.frame(head),
		.frame_pop(pop),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.out_data(res)
	);

	assign results.gain_fixed = res.gain_fixed;
	assign results.gain_whole = res.gain_whole;
	assign results.frame_level = res.frame_level;

endmodule

// ----- rtl/core/frgt_front.sv -----
// ----------------------------------------------------------------------------
// frgt_front
// sign handling, squaring and saturating accumulation of the samples
// ----------------------------------------------------------------------------
module frgt_front import frgt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic active,
	input logic [1:0] sample_format,
	input logic in_valid,
	output logic in_ready,
	input logic [31:0] sample_word,
	input logic frame_last,
	output logic push,
	output frame_t push_data,
	input logic queue_full
);

	// stage 1 holds the magnitude, stage 2 the square
	logic vld_s1, last_s1, act_s1, cnt_s1;
	logic [31:0] mag_s1;
	logic vld_s2, last_s2, act_s2, cnt_s2;
	logic [63:0] sq_s2;
	logic [63:0] sum_q;
	logic [CountW-1:0] cnt_q;
	logic [63:0] sum_next;
	logic [64:0] add_w;
	logic [31:0] mag_w, ext_w;
	logic stall;
	logic in_fire;
	logic [CountW-1:0] cnt_ahead;

	// a frame end needs room in the queue
	assign stall = vld_s2 && last_s2 && act_s2 && queue_full;
	assign in_ready = !stall;
	assign in_fire = in_valid && in_ready;

	always_comb begin
		case (sample_format)
			FmtInt8: ext_w = {{24{sample_word[7]}}, sample_word[7:0]};
			FmtInt16: ext_w = {{16{sample_word[15]}}, sample_word[15:0]};
			FmtInt24: ext_w = {{8{sample_word[23]}}, sample_word[23:0]};
			default: ext_w = sample_word;
		endcase
		mag_w = ext_w[31] ? (32'd0 - ext_w) : ext_w;
	end

	// samples in flight ahead of the accumulator count toward the frame limit,
	// a frame end or an inactive item in flight starts the count over
	always_comb begin
		if (vld_s1 && (last_s1 || !act_s1)) begin
			cnt_ahead = '0;
		end else if (vld_s2 && (last_s2 || !act_s2)) begin
			cnt_ahead = CountW'(vld_s1 && cnt_s1);
		end else begin
			cnt_ahead = cnt_q + CountW'(vld_s1 && cnt_s1) + CountW'(vld_s2 && cnt_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= in_fire;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			mag_s1 <= mag_w;
			last_s1 <= frame_last;
			act_s1 <= active;
			last_s2 <= last_s1;
			act_s2 <= act_s1;
			cnt_s2 <= cnt_s1;
			sq_s2 <= 64'(mag_s1) * 64'(mag_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 1'b0;
		end else if (!stall) begin
			cnt_s1 <= cnt_ahead < CountW'(MaxFrameSamples);
		end
	end

	always_comb begin
		add_w = {1'b0, sum_q} + {1'b0, sq_s2};
		sum_next = add_w[64] ? '1 : add_w[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (vld_s2 && !stall) begin
			if (!act_s2 || last_s2) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (cnt_s2) begin
				sum_q <= sum_next;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign push = vld_s2 && act_s2 && last_s2 && !queue_full;
	always_comb begin
		push_data.square_sum = cnt_s2 ? sum_next : sum_q;
		push_data.sample_count = cnt_s2 ? cnt_q + 1'b1 : cnt_q;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CountW'(MaxFrameSamples)) else $error("count over limit");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full) else $error("push into full queue");
	a_push_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_data.sample_count != '0) else $error("empty frame");

endmodule

// ----- rtl/core/frgt_queue.sv -----
// ----------------------------------------------------------------------------
// frgt_queue
// short fifo of finished frames between front and back
// ----------------------------------------------------------------------------
module frgt_queue import frgt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input frame_t push_data,
	output logic full,
	output logic nonempty,
	input logic pop,
	output frame_t head
);

	frame_t mem_q [QueueDepth];
	logic [QueueAw-1:0] wp_q, rp_q;
	logic [QueueAw:0] fill_q;

	assign full = fill_q == (QueueAw+1)'(QueueDepth);
	assign nonempty = fill_q != '0;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			fill_q <= fill_q + (QueueAw+1)'(push) - (QueueAw+1)'(pop);
		end
	end

	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue underflow");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (QueueAw+1)'(QueueDepth)) else $error("fill over depth");

endmodule

// ----- rtl/core/frgt_back.sv -----
// ----------------------------------------------------------------------------
// frgt_back
// frame end: mean by restoring divide, root by digit recurrence, gain update
// ----------------------------------------------------------------------------
module frgt_back import frgt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic gain_reset,
	input logic [30:0] target_level,
	input logic frame_valid,
	input frame_t frame,
	output logic frame_pop,
	output logic out_valid,
	input logic out_ready,
	output result_t out_data
);

	localparam logic [2:0] StIdle = 3'd0;
	localparam logic [2:0] StDiv = 3'd1;
	localparam logic [2:0] StSqrt = 3'd2;
	localparam logic [2:0] StErr = 3'd3;
	localparam logic [2:0] StMul = 3'd4;
	localparam logic [2:0] StQuo = 3'd5;
	localparam logic [2:0] StGain = 3'd6;
	localparam logic [2:0] StOut = 3'd7;

	// ceil(2^55/625), exact for dividends below 2^46
	localparam logic [47:0] RecipM = 48'((64'd1 << 55) / 64'd625 + 64'd1);

	logic [2:0] state_q;
	logic [5:0] step_q;
	logic [63:0] num_q;          // dividend shifting into quotient, then sqrt operand
	logic [CountW-1:0] rem_q;
	logic [CountW-1:0] den_q;
	logic [31:0] root_q;
	logic [33:0] srem_q;
	logic signed [47:0] perr_q;
	logic signed [47:0] err_q;
	logic signed [47:0] diff_q;
	logic neg_q;
	logic [47:0] prod_q;
	logic [95:0] acc_q;
	logic signed [31:0] gain_q;
	logic [31:0] level_q;
	logic [15:0] whole_q;
	result_t res_q;
	logic vld_q;

	logic [CountW:0] dtry;
	logic [33:0] strial, sshift;
	logic [47:0] dmag;
	logic [23:0] mul_a, mul_b;
	logic [47:0] pp;
	logic [95:0] pp_sh;
	logic [47:0] quo_w;
	logic signed [49:0] gsum;
	logic signed [31:0] gsat;
	logic signed [31:0] whole;

	always_comb begin
		dtry = {rem_q, num_q[63]} - {1'b0, den_q};
		sshift = {srem_q[31:0], num_q[63:62]};
		strial = sshift - {root_q, 2'b01};
		dmag = diff_q[47] ? (48'd0 - diff_q) : diff_q;
		// divide by 625 via reciprocal, one 24x24 partial product per cycle
		mul_a = step_q[1] ? prod_q[47:24] : prod_q[23:0];
		mul_b = step_q[0] ? RecipM[47:24] : RecipM[23:0];
		pp = mul_a * mul_b;
		case (step_q[1:0])
			2'd0: pp_sh = {48'd0, pp};
			2'd3: pp_sh = {pp, 48'd0};
			default: pp_sh = {24'd0, pp, 24'd0};
		endcase
		quo_w = {7'd0, acc_q[95:55]};
		gsum = 50'(gain_q) + (neg_q ? -50'(signed'({1'b0, quo_w})) : 50'(signed'({1'b0, quo_w})));
		if (gsum > 50'sh7FFF_FFFF) gsat = 32'sh7FFF_FFFF;
		else if (gsum < -50'sh8000_0000) gsat = 32'sh8000_0000;
		else gsat = gsum[31:0];
		whole = gsat / 32'sd65536;
	end

	assign frame_pop = state_q == StIdle && frame_valid && !gain_reset;
	assign out_valid = vld_q;
	assign out_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			gain_q <= signed'(GainOne);
			perr_q <= '0;
			vld_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (vld_q && out_ready) vld_q <= 1'b0;
			if (gain_reset) begin
				gain_q <= signed'(GainOne);
				perr_q <= '0;
			end
			case (state_q)
				StIdle: begin
					if (frame_pop) begin
						state_q <= StDiv;
						step_q <= '0;
					end
				end
				StDiv: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd63) state_q <= StSqrt;
				end
				StSqrt: begin
					step_q <= step_q + 1'b1;
					if (step_q == 6'd31) state_q <= StErr;
				end
				StErr: state_q <= StMul;
				StMul: begin
					step_q <= '0;
					state_q <= StQuo;
				end
				StQuo: begin
					// four partial products of the reciprocal multiply
					step_q <= step_q + 1'b1;
					if (step_q == 6'd3) state_q <= StGain;
				end
				StGain: begin
					gain_q <= gsat;
					perr_q <= err_q;
					state_q <= StOut;
				end
				StOut: begin
					if (!vld_q || out_ready) begin
						vld_q <= 1'b1;
						state_q <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			StIdle: begin
				num_q <= frame.square_sum;
				den_q <= frame.sample_count;
				rem_q <= '0;
			end
			StDiv: begin
				if (!dtry[CountW]) begin
					rem_q <= dtry[CountW-1:0];
					num_q <= {num_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[CountW-2:0], num_q[63]};
					num_q <= {num_q[62:0], 1'b0};
				end
				root_q <= '0;
				srem_q <= '0;
			end
			StSqrt: begin
				num_q <= {num_q[61:0], 2'b00};
				if (!strial[33]) begin
					srem_q <= strial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= sshift;
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			StErr: begin
				level_q <= root_q;
				err_q <= 48'(root_q) - 48'(target_level);
				diff_q <= 48'(root_q) - 48'(target_level) - perr_q;
			end
			StMul: begin
				// magnitude of the error change stays below 2^32
				neg_q <= diff_q[47];
				prod_q <= {dmag[35:0], 12'd0} + 48'd312;
				acc_q <= '0;
			end
			StQuo: begin
				acc_q <= acc_q + pp_sh;
			end
			StGain: begin
				whole_q <= whole[15:0];
			end
			StOut: begin
				if (!vld_q || out_ready) begin
					res_q.gain_fixed <= gain_q;
					res_q.gain_whole <= whole_q;
					res_q.frame_level <= level_q;
				end
			end
			default: ;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && !out_ready |=> vld_q) else $error("result dropped");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pop |=> state_q == StDiv) else $error("pop without start");
	a_quo_fit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StGain |-> acc_q[95:91] == '0) else $error("quotient out of range");

endmodule

// ----- sim/tb_frame_rms_gain_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_frame_rms_gain_tracker
// checks the rms gain tracker against a cycle-free predictor of frame levels
// and gains, under several register settings and random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_frame_rms_gain_tracker;
	import frgt_pkg::*;

	localparam int WatchdogLimit = 20000;

	typedef struct {
		logic [31:0] word;
		logic last;
	} sample_t;

	typedef struct {
		logic [31:0] gain_fixed;
		logic [15:0] gain_whole;
		logic [31:0] frame_level;
	} gain_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CfgEnable;
	logic [30:0] cfg_data = '0;

	frgt_sample_if samples ();
	frgt_result_if results ();

	frame_rms_gain_tracker dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .samples(samples.sink), .results(results.source)
	);

	always #5 clk = ~clk;

	// predictor state
	logic m_enable = 1'b0;
	logic [30:0] m_target = 31'd100;
	logic [1:0] m_format = FmtInt16;
	logic [63:0] m_sum = '0;
	logic [12:0] m_count = '0;
	longint m_prev_err = 0;
	logic signed [31:0] m_gain = GainOne;

	sample_t pending_samples[$];
	gain_t expected_gains[$];
	int send_idle = 0;
	int recv_idle = 0;
	int hold_off = 0;
	int quiet_cycles = 0;
	bit failed = 0;

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void track_gain(sample_t s);
		int bits;
		logic [63:0] v;
		logic [63:0] sq;
		logic [63:0] mean;
		logic [63:0] level;
		longint err;
		longint diff;
		longint delta;
		longint g;
		logic [63:0] mag;
		gain_t r;
		if (!m_enable || m_target == 0) begin
			m_sum = '0;
			m_count = '0;
			return;
		end
		if (m_count < MaxFrameSamples) begin
			bits = 8 * (m_format + 1);
			v = 64'(s.word) & ((64'd1 << bits) - 1);
			if (v[bits-1]) v = (64'd1 << bits) - v;
			sq = v * v;
			if (m_sum > ~sq) m_sum = '1;
			else m_sum += sq;
			m_count++;
		end
		if (!s.last) return;
		mean = m_sum / 64'(m_count);
		level = root_floor(mean);
		err = longint'(level) - longint'(m_target);
		diff = err - m_prev_err;
		mag = 64'(diff < 0 ? -diff : diff) * 64'd4096;
		delta = longint'((mag + 64'd312) / 64'd625);
		if (diff < 0) delta = -delta;
		g = longint'(m_gain) + delta;
		if (g > 64'sd2147483647) g = 64'sd2147483647;
		if (g < -64'sd2147483648) g = -64'sd2147483648;
		m_gain = 32'(g);
		m_prev_err = err;
		m_sum = '0;
		m_count = '0;
		r.gain_fixed = m_gain;
		r.gain_whole = 16'(m_gain / 65536);
		r.frame_level = level[31:0];
		expected_gains.push_back(r);
	endfunction

	// driver
	always @(posedge clk) begin
		sample_t s;
		if (samples.valid && samples.ready) begin
			track_gain('{samples.sample_word, samples.frame_last});
		end
		if (!(samples.valid && !samples.ready)) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
				s = pending_samples.pop_front();
				samples.valid <= 1'b1;
				samples.sample_word <= s.word;
				samples.frame_last <= s.last;
			end else begin
				samples.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		gain_t e;
		if (results.valid && results.ready) begin
			if (expected_gains.size() == 0) begin
				$error("unexpected result item gain_fixed %h", results.gain_fixed);
				failed = 1;
			end else begin
				e = expected_gains.pop_front();
				if (results.gain_fixed !== e.gain_fixed) begin
					$error("gain_fixed expected %h actual %h", e.gain_fixed, results.gain_fixed);
					failed = 1;
				end
				if (results.gain_whole !== e.gain_whole) begin
					$error("gain_whole expected %h actual %h", e.gain_whole, results.gain_whole);
					failed = 1;
				end
				if (results.frame_level !== e.frame_level) begin
					$error("frame_level expected %0d actual %0d", e.frame_level,
						results.frame_level);
					failed = 1;
				end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			results.ready <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((samples.valid && samples.ready) || (results.valid && results.ready)
			|| pending_samples.size() == 0 && expected_gains.size() == 0 && !samples.valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [30:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CfgEnable) begin
			m_enable = val[0];
			if (val[0]) begin
				m_gain = GainOne;
				m_prev_err = 0;
			end
		end else if (idx == CfgTarget) begin
			m_target = val;
		end else if (idx == CfgFormat) begin
			m_format = val[1:0];
		end
	endtask

	task automatic drain();
		wait (pending_samples.size() == 0 && !samples.valid && expected_gains.size() == 0);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(4))
			0: return $urandom_range(15);
			1: return 32'hFFFF_FFFF - $urandom_range(15);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_frames(int n_items);
		int len;
		int left;
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				pending_samples.push_back('{rand_word(), i == len - 1});
			left -= len;
		end
	endtask

	initial begin
		samples.valid = 1'b0;
		samples.sample_word = '0;
		samples.frame_last = 1'b0;
		results.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 13;
		recv_idle = 52;

		// disabled: nothing comes out
		pending_samples.push_back('{32'h1234, 1'b1});
		drain();
		write_reg(CfgEnable, 31'd1);
		// directed: extremes per format
		for (int f = 0; f < 4; f++) begin
			write_reg(CfgFormat, 31'(f));
			pending_samples.push_back('{32'h0000_0000, 1'b1});
			pending_samples.push_back('{32'hFFFF_FFFF, 1'b0});
			pending_samples.push_back('{32'h8080_8080, 1'b1});
			pending_samples.push_back('{32'h7F7F_7F7F, 1'b1});
			pending_samples.push_back('{32'h8000_0000, 1'b1});
			drain();
		end
		// saturating sum at int32
		write_reg(CfgTarget, 31'h7FFF_FFFF);
		for (int i = 0; i < 20; i++)
			pending_samples.push_back('{32'h8000_0000, i == 19});
		drain();
		// target zero suspends updates
		write_reg(CfgTarget, 31'd0);
		pending_samples.push_back('{32'h7FFF, 1'b1});
		drain();
		write_reg(CfgTarget, 31'd1);
		pending_samples.push_back('{32'h7FFF_FFFF, 1'b1});
		pending_samples.push_back('{32'h0, 1'b1});
		drain();

		queue_frames(480);
		drain();
		send_idle = 52;
		recv_idle = 13;
		write_reg(CfgFormat, 31'(FmtInt8));
		write_reg(CfgTarget, 31'(20 + $urandom_range(100)));
		write_reg(CfgEnable, 31'd0);
		pending_samples.push_back('{32'h55, 1'b1});
		drain();
		write_reg(CfgEnable, 31'd1);
		queue_frames(480);
		drain();
		send_idle = 0;
		recv_idle = 0;
		write_reg(CfgFormat, 31'(FmtInt24));
		write_reg(CfgTarget, 31'($urandom));
		// long stall so the frame queue fills
		hold_off = 2000;
		for (int i = 0; i < 60; i++)
			pending_samples.push_back('{rand_word(), 1'b1});
		drain();
		write_reg(CfgFormat, 31'(FmtInt32));
		write_reg(CfgTarget, 31'd5000);
		queue_frames(480);
		drain();
		if (!failed) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
